### src/sfm_pkg.sv
// shared types and constants of the servo status frame matcher
package sfm_pkg;

  localparam int MAX_PARAMS = 8;
  localparam int RX_LIMIT   = 259;
  localparam int WIN        = MAX_PARAMS + 6;
  localparam int WIN_W      = $clog2(WIN);
  localparam int IDX_W      = $clog2(MAX_PARAMS);
  localparam int BEAT_W     = $clog2(MAX_PARAMS + 1);
  localparam int CNT_W      = 4;
  localparam int LEN_W      = 9;
  localparam int RXC_W      = 9;
  localparam int TICK_W     = 16;

  localparam logic [7:0]        HDR_BYTE = 8'hFF;
  localparam logic [7:0]        TOP_ID   = 8'd253;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  localparam logic [1:0] CFG_ID      = 2'd0;
  localparam logic [1:0] CFG_COUNT   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_REQ   = 2'd1,
    FN_RX    = 2'd2,
    FN_TICK  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DEV_ERR = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic clr;
    logic win_shift;
    logic req_shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic                         vld;
    status_t                      st;
    logic [7:0]                   err;
    logic [BEAT_W-1:0]            beats;
    logic [MAX_PARAMS-1:0][7:0]   prm;
  } emit_req_t;

endpackage

### src/sfm_cell.sv
// one window cell: bus byte, request byte and suffix sum of the window
module sfm_cell (
  input  logic                clk,
  input  sfm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          win_in,
  input  logic [7:0]          req_in,
  input  logic [7:0]          sum_in,
  input  logic [7:0]          rx_byte,
  output logic [7:0]          win_o,
  output logic [7:0]          req_o,
  output logic [7:0]          sum_o,
  output logic                eq_o
);

  logic [7:0] win_r, win_nxt;
  logic [7:0] req_r, req_nxt;
  logic [7:0] sum_r, sum_nxt;

  always_comb begin
    win_nxt = win_r;
    sum_nxt = sum_r;
    req_nxt = req_r;
    if (ctrl.clr) begin
      win_nxt = '0;
      sum_nxt = '0;
    end else if (ctrl.win_shift) begin
      win_nxt = win_in;
      sum_nxt = sum_in + rx_byte;
    end
    if (ctrl.req_shift) begin
      req_nxt = req_in;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    sum_r <= sum_nxt;
    req_r <= req_nxt;
  end

  // compares the byte this cell would hold after the shift
  assign eq_o  = (win_in == req_r);
  assign win_o = win_r;
  assign req_o = req_r;
  assign sum_o = sum_r;

endmodule

### src/sfm_emit.sv
// output stage that plays out the results of one transaction
module sfm_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfm_pkg::emit_req_t   ld,
  output logic                 free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);

  logic                                     vld_r, vld_nxt;
  logic [sfm_pkg::BEAT_W-1:0]               rem_r, rem_nxt;
  logic [sfm_pkg::IDX_W-1:0]                idx_r, idx_nxt;
  sfm_pkg::status_t                         st_r, st_nxt;
  logic [7:0]                               err_r, err_nxt;
  logic [sfm_pkg::MAX_PARAMS-1:0][7:0]      prm_r, prm_nxt;
  logic                                     beat;
  logic                                     last;

  assign beat = vld_r & out_tready;
  assign last = (rem_r == sfm_pkg::BEAT_W'(1));
  assign free = ~vld_r | (beat & last);

  always_comb begin
    vld_nxt = vld_r;
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    st_nxt  = st_r;
    err_nxt = err_r;
    prm_nxt = prm_r;
    if (beat) begin
      if (last) begin
        vld_nxt = 1'b0;
      end else begin
        rem_nxt = rem_r - sfm_pkg::BEAT_W'(1);
        idx_nxt = idx_r + sfm_pkg::IDX_W'(1);
        prm_nxt = {8'h00, prm_r[sfm_pkg::MAX_PARAMS-1:1]};
      end
    end
    if (ld.vld) begin
      vld_nxt = 1'b1;
      rem_nxt = ld.beats;
      idx_nxt = '0;
      st_nxt  = ld.st;
      err_nxt = ld.err;
      prm_nxt = ld.prm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
    st_r  <= st_nxt;
    err_r <= err_nxt;
    prm_r <= prm_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = last;
  assign out_tuser  = st_r;
  assign out_tdata  = {5'd0, prm_r[0], idx_r, err_r};

endmodule

### src/servo_status_frame_matcher_top.sv
// top level of the servo status frame matcher
// Takes one request per clock while in_tready is high: start, request frame byte, bus byte or
// timer tick. Bus bytes shift through a row of 14 cells that keep the newest window, the loaded
// request frame and running suffix sums, so frame, checksum and echo checks settle in the
// accepting cycle. A match plays out one result per parameter byte (one result if the frame has
// none) through a single output register, one per cycle while out_tready is high; in_tready is
// held low until the output register has handed over its last result. A failure gives one result.
module servo_status_frame_matcher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // error_code, param_index, param_byte, zero pad
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int W = sfm_pkg::WIN;

  logic [7:0]                       id_r;
  logic [sfm_pkg::CNT_W-1:0]        cnt_r;
  logic [sfm_pkg::TICK_W-1:0]       tmo_r;
  logic [sfm_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [sfm_pkg::RXC_W-1:0]        rxc_r, rxc_nxt;
  logic [sfm_pkg::TICK_W-1:0]       et_r, et_nxt;
  logic                             fin_r, fin_nxt;

  logic                             acc;
  sfm_pkg::func_t                   fn;
  sfm_pkg::cell_ctrl_t              ctrl;
  sfm_pkg::emit_req_t               ld;
  logic                             free;

  logic [7:0] win_o [W];
  logic [7:0] req_o [W];
  logic [7:0] sum_o [W];
  logic [7:0] v     [W];
  logic [W-1:0] eq;

  logic                             cnt_ok;
  logic [sfm_pkg::WIN_W-1:0]        base;
  logic [sfm_pkg::LEN_W-1:0]        rs;
  logic                             hit;
  logic                             echo;
  logic [7:0]                       err_b;
  logic [sfm_pkg::MAX_PARAMS-1:0][7:0] prm;
  logic [4:0]                       pidx;
  logic [sfm_pkg::TICK_W-1:0]       lim;

  assign cfg_ready = 1'b1;
  assign in_tready = free;
  assign acc       = in_tvalid & free;
  assign fn        = sfm_pkg::func_t'(in_tuser);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r  <= 8'd1;
      cnt_r <= sfm_pkg::CNT_W'(2);
      tmo_r <= sfm_pkg::TICK_W'(10);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfm_pkg::CFG_ID:      id_r  <= cfg_data[7:0];
        sfm_pkg::CFG_COUNT:   cnt_r <= cfg_data[sfm_pkg::CNT_W-1:0];
        sfm_pkg::CFG_TIMEOUT: tmo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // window cells, newest byte at the top end
  for (genvar i = 0; i < W; i++) begin : g_cell
    logic [7:0] win_in, req_in, sum_in;
    if (i == W - 1) begin : g_top
      assign win_in = in_tdata;
      assign req_in = in_tdata;
      assign sum_in = 8'h00;
    end else begin : g_mid
      assign win_in = win_o[i+1];
      assign req_in = req_o[i+1];
      assign sum_in = sum_o[i+1];
    end
    assign v[i] = win_in;
    sfm_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .win_in  (win_in),
      .req_in  (req_in),
      .sum_in  (sum_in),
      .rx_byte (in_tdata),
      .win_o   (win_o[i]),
      .req_o   (req_o[i]),
      .sum_o   (sum_o[i]),
      .eq_o    (eq[i])
    );
  end

  // frame check on the window as it stands after this byte
  always_comb begin
    cnt_ok = (cnt_r <= sfm_pkg::CNT_W'(sfm_pkg::MAX_PARAMS));
    base   = cnt_ok ? sfm_pkg::WIN_W'(W - 6) - sfm_pkg::WIN_W'(cnt_r) : '0;
    rs     = sfm_pkg::LEN_W'(cnt_r) + sfm_pkg::LEN_W'(6);
    echo   = (len_r == rs);
    for (int i = 0; i < W; i++) begin
      if (sfm_pkg::WIN_W'(i) >= base && !eq[i]) echo = 1'b0;
    end
    err_b = v[base + sfm_pkg::WIN_W'(4)];
    hit   = cnt_ok && (rxc_nxt >= rs)
            && (v[base] == sfm_pkg::HDR_BYTE)
            && (v[base + sfm_pkg::WIN_W'(1)] == sfm_pkg::HDR_BYTE)
            && (v[base + sfm_pkg::WIN_W'(2)] == id_r)
            && (v[base + sfm_pkg::WIN_W'(3)] == 8'(cnt_r) + 8'd2)
            && (in_tdata == ~sum_o[base + sfm_pkg::WIN_W'(3)])
            && !echo;
    for (int k = 0; k < sfm_pkg::MAX_PARAMS; k++) begin
      pidx   = 5'(base) + 5'(5 + k);
      prm[k] = 8'h00;
      if (k < int'(cnt_r) && pidx < 5'(W)) prm[k] = v[pidx[sfm_pkg::WIN_W-1:0]];
    end
  end

  assign rxc_nxt = rxc_r + sfm_pkg::RXC_W'(1);
  assign lim     = (tmo_r == '0) ? sfm_pkg::TICK_W'(1) : tmo_r;

  always_comb begin
    len_nxt  = len_r;
    et_nxt   = et_r;
    fin_nxt  = fin_r;
    ctrl     = '0;
    ld       = '0;
    ld.beats = sfm_pkg::BEAT_W'(1);
    ld.st    = sfm_pkg::ST_INVALID;
    if (acc) begin
      unique case (fn)
        sfm_pkg::FN_START: begin
          ctrl.clr = 1'b1;
          len_nxt  = '0;
          et_nxt   = '0;
          fin_nxt  = 1'b0;
          if (id_r > sfm_pkg::TOP_ID || !cnt_ok) begin
            fin_nxt = 1'b1;
            ld.vld  = 1'b1;
          end
        end
        sfm_pkg::FN_REQ: begin
          if (!fin_r) begin
            ctrl.req_shift = (len_r < sfm_pkg::LEN_W'(W));
            if (len_r != sfm_pkg::LEN_MAX) len_nxt = len_r + sfm_pkg::LEN_W'(1);
          end
        end
        sfm_pkg::FN_RX: begin
          if (!fin_r) begin
            ctrl.win_shift = 1'b1;
            if (hit) begin
              fin_nxt  = 1'b1;
              ld.vld   = 1'b1;
              ld.st    = (err_b == 8'h00) ? sfm_pkg::ST_OK : sfm_pkg::ST_DEV_ERR;
              ld.err   = err_b;
              ld.prm   = prm;
              ld.beats = (cnt_r == '0) ? sfm_pkg::BEAT_W'(1) : sfm_pkg::BEAT_W'(cnt_r);
            end else if (rxc_nxt >= sfm_pkg::RXC_W'(sfm_pkg::RX_LIMIT)) begin
              fin_nxt = 1'b1;
              ld.vld  = 1'b1;
            end
          end
        end
        sfm_pkg::FN_TICK: begin
          if (!fin_r) begin
            if (et_r != sfm_pkg::TICK_MAX) et_nxt = et_r + sfm_pkg::TICK_W'(1);
            if (et_nxt > lim) begin
              fin_nxt = 1'b1;
              ld.vld  = 1'b1;
              ld.st   = (rxc_r == '0) ? sfm_pkg::ST_TIMEOUT : sfm_pkg::ST_INVALID;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      rxc_r <= '0;
      et_r  <= '0;
      fin_r <= 1'b1;
    end else begin
      len_r <= len_nxt;
      et_r  <= et_nxt;
      fin_r <= fin_nxt;
      if (ctrl.clr) begin
        rxc_r <= '0;
      end else if (ctrl.win_shift) begin
        rxc_r <= rxc_nxt;
      end
    end
  end

  sfm_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### verif/tb_top.sv
// self-checking testbench for the servo status frame matcher: frames, echo, timer, registers
module tb_top;

  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 40;

  typedef struct packed {
    sfm_pkg::status_t st;
    logic [7:0]       err;
    logic [2:0]       idx;
    logic [7:0]       pb;
    logic             last;
  } status_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;

  // predictor state
  logic [7:0]  win_bytes [sfm_pkg::WIN];
  logic [7:0]  req_bytes [sfm_pkg::WIN];
  int          req_len;
  int          rx_seen;
  int          ticks_seen;
  bit          txn_done;
  logic [7:0]  reg_id;
  logic [3:0]  reg_count;
  logic [15:0] reg_timeout;

  status_beat_t status_beats_due [$];
  logic [7:0]   frame_bytes [$];
  logic [7:0]   req_frame [$];

  int mismatch_count = 0;
  int beats_seen = 0;
  int live_items = 0;
  int txn_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int pat_left = 0;
  logic [7:0] stall_pat = 8'hFF;

  always #1 clk = ~clk;

  servo_status_frame_matcher_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic void push_beat(sfm_pkg::status_t st, logic [7:0] err, logic [2:0] idx,
                                    logic [7:0] pb, logic last);
    status_beat_t b;
    b.st   = st;
    b.err  = err;
    b.idx  = idx;
    b.pb   = pb;
    b.last = last;
    status_beats_due.push_back(b);
  endfunction

  function automatic void fail_txn();
    push_beat(rx_seen == 0 ? sfm_pkg::ST_TIMEOUT : sfm_pkg::ST_INVALID, 8'h00, 3'd0, 8'h00,
              1'b1);
    txn_done = 1'b1;
  endfunction

  // size of a valid non-echo status frame at the newest end of the window, else 0
  function automatic int status_frame_size();
    int rs;
    int base;
    logic [7:0] sum;
    bit echo;
    if (reg_count > sfm_pkg::MAX_PARAMS) return 0;
    rs = reg_count + 6;
    if (rx_seen < rs) return 0;
    base = sfm_pkg::WIN - rs;
    if (win_bytes[base] != sfm_pkg::HDR_BYTE || win_bytes[base+1] != sfm_pkg::HDR_BYTE)
      return 0;
    if (win_bytes[base+2] != reg_id) return 0;
    if (win_bytes[base+3] != reg_count + 2) return 0;
    sum = 8'h00;
    for (int i = 2; i < rs - 1; i++) sum = sum + win_bytes[base+i];
    if (win_bytes[base+rs-1] != ~sum) return 0;
    if (req_len == rs) begin
      echo = 1'b1;
      for (int i = 0; i < rs; i++)
        if (win_bytes[base+i] != req_bytes[i]) echo = 1'b0;
      if (echo) return 0;
    end
    return rs;
  endfunction

  function automatic void predict_bus_item(sfm_pkg::func_t f, logic [7:0] d);
    int rs;
    int base;
    int cnt;
    int lim;
    logic [7:0] err;
    sfm_pkg::status_t st;
    if (f == sfm_pkg::FN_START) begin
      for (int i = 0; i < sfm_pkg::WIN; i++) win_bytes[i] = 8'h00;
      req_len = 0;
      rx_seen = 0;
      ticks_seen = 0;
      txn_done = 1'b0;
      if (reg_id > sfm_pkg::TOP_ID || reg_count > sfm_pkg::MAX_PARAMS) begin
        push_beat(sfm_pkg::ST_INVALID, 8'h00, 3'd0, 8'h00, 1'b1);
        txn_done = 1'b1;
      end
    end else if (!txn_done) begin
      case (f)
        sfm_pkg::FN_REQ: begin
          if (req_len < sfm_pkg::WIN) req_bytes[req_len] = d;
          if (req_len < int'(sfm_pkg::LEN_MAX)) req_len++;
        end
        sfm_pkg::FN_RX: begin
          for (int i = 0; i < sfm_pkg::WIN - 1; i++) win_bytes[i] = win_bytes[i+1];
          win_bytes[sfm_pkg::WIN-1] = d;
          rx_seen++;
          rs = status_frame_size();
          if (rs != 0) begin
            base = sfm_pkg::WIN - rs;
            cnt  = rs - 6;
            err  = win_bytes[base+4];
            st   = (err == 8'h00) ? sfm_pkg::ST_OK : sfm_pkg::ST_DEV_ERR;
            txn_done = 1'b1;
            if (cnt == 0)
              push_beat(st, err, 3'd0, 8'h00, 1'b1);
            else
              for (int k = 0; k < cnt; k++)
                push_beat(st, err, 3'(k), win_bytes[base+5+k], k + 1 == cnt);
          end else if (rx_seen >= sfm_pkg::RX_LIMIT) begin
            fail_txn();
          end
        end
        default: begin
          lim = (reg_timeout == 16'h0000) ? 1 : int'(reg_timeout);
          if (ticks_seen < int'(sfm_pkg::TICK_MAX)) ticks_seen++;
          if (ticks_seen > lim) fail_txn();
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : beat_check
    status_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (status_beats_due.size() == 0) begin
        report_mismatch("status beat with nothing due");
      end else begin
        want = status_beats_due.pop_front();
        if (out_tuser !== want.st)
          report_mismatch($sformatf("status %0d, due %0d", out_tuser, want.st));
        if (out_tdata[7:0] !== want.err)
          report_mismatch($sformatf("error_code %0h, due %0h", out_tdata[7:0], want.err));
        if (out_tdata[10:8] !== want.idx)
          report_mismatch($sformatf("param_index %0d, due %0d", out_tdata[10:8], want.idx));
        if (out_tdata[18:11] !== want.pb)
          report_mismatch($sformatf("param_byte %0h, due %0h", out_tdata[18:11], want.pb));
        if (out_tdata[23:19] !== 5'd0)
          report_mismatch($sformatf("pad bits %0h", out_tdata[23:19]));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %0b, due %0b", out_tlast, want.last));
      end
    end
  end

  // receiver stall pattern, reloaded whenever its random countdown runs out
  always @(negedge clk) begin
    if (pat_left == 0) begin
      pat_left   <= $urandom_range(8, 40);
      stall_pat  <= 8'($urandom) | 8'h01;
      out_tready <= 1'b1;
    end else begin
      pat_left   <= pat_left - 1;
      out_tready <= !stall_on || stall_pat[pat_left % 8];
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input sfm_pkg::func_t f, input logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
    end else begin
      gap = 0;
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    if (f == sfm_pkg::FN_START) txn_count++;
    if (f == sfm_pkg::FN_START || !txn_done) live_items++;
    predict_bus_item(f, d);
  endtask

  task automatic send_frame(input sfm_pkg::func_t f, input bit from_req, input int tick_pct);
    int n;
    logic [7:0] b;
    n = from_req ? req_frame.size() : frame_bytes.size();
    for (int i = 0; i < n; i++) begin
      b = from_req ? req_frame[i] : frame_bytes[i];
      if ($urandom_range(0, 99) < tick_pct) send_item(sfm_pkg::FN_TICK, 8'($urandom));
      send_item(f, b);
    end
  endtask

  task automatic tick_until_done();
    while (!txn_done) send_item(sfm_pkg::FN_TICK, 8'($urandom));
  endtask

  // FF FF id len err params checksum; fill < 0 gives random params
  task automatic make_frame(input logic [7:0] id, input int cnt, input logic [7:0] err,
                            input int fill);
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    len = 8'(cnt + 2);
    frame_bytes.delete();
    frame_bytes.push_back(sfm_pkg::HDR_BYTE);
    frame_bytes.push_back(sfm_pkg::HDR_BYTE);
    frame_bytes.push_back(id);
    frame_bytes.push_back(len);
    frame_bytes.push_back(err);
    sum = id + len + err;
    for (int i = 0; i < cnt; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      frame_bytes.push_back(b);
      sum = sum + b;
    end
    frame_bytes.push_back(~sum);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (status_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sfm_pkg::CFG_ID:      reg_id = val[7:0];
      sfm_pkg::CFG_COUNT:   reg_count = val[3:0];
      sfm_pkg::CFG_TIMEOUT: reg_timeout = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] id, input logic [3:0] cnt, input logic [15:0] tmo);
    logic [15:0] v;
    wait_idle();
    v = 16'($urandom);
    v[7:0] = id;
    write_reg(sfm_pkg::CFG_ID, v);
    v = 16'($urandom);
    v[3:0] = cnt;
    write_reg(sfm_pkg::CFG_COUNT, v);
    write_reg(sfm_pkg::CFG_TIMEOUT, tmo);
  endtask

  task automatic test_frame_matches();
    configure(8'd1, 4'd2, 16'd10);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    make_frame(8'd1, 2, 8'h00, -1);
    send_frame(sfm_pkg::FN_RX, 1'b0, 0);
    send_item(sfm_pkg::FN_TICK, 8'($urandom));
    configure(8'd0, 4'd0, 16'd10);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    make_frame(8'd0, 0, 8'h80, -1);
    send_frame(sfm_pkg::FN_RX, 1'b0, 0);
    configure(sfm_pkg::TOP_ID, 4'(sfm_pkg::MAX_PARAMS), 16'd10);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    make_frame(sfm_pkg::TOP_ID, sfm_pkg::MAX_PARAMS, 8'hFF, 255);
    send_frame(sfm_pkg::FN_RX, 1'b0, 0);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    make_frame(sfm_pkg::TOP_ID, sfm_pkg::MAX_PARAMS, 8'h00, 0);
    send_frame(sfm_pkg::FN_RX, 1'b0, 0);
  endtask

  task automatic test_echo_rejection();
    configure(8'd5, 4'd1, 16'd10);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    make_frame(8'd5, 1, 8'h00, -1);
    req_frame = frame_bytes;
    send_frame(sfm_pkg::FN_REQ, 1'b1, 0);
    send_frame(sfm_pkg::FN_RX, 1'b1, 0);
    send_frame(sfm_pkg::FN_RX, 1'b1, 0);
    make_frame(8'd5, 1, 8'h04, -1);
    send_frame(sfm_pkg::FN_RX, 1'b0, 0);
  endtask

  task automatic test_bad_config();
    configure(8'd254, 4'd2, 16'd10);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    send_item(sfm_pkg::FN_REQ, 8'hFF);
    send_item(sfm_pkg::FN_RX, 8'hFF);
    send_item(sfm_pkg::FN_TICK, 8'($urandom));
    configure(8'd255, 4'd2, 16'd10);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    configure(8'd1, 4'd9, 16'd10);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    configure(8'd1, 4'd15, 16'd10);
    send_item(sfm_pkg::FN_START, 8'($urandom));
  endtask

  task automatic test_timer_expiry();
    configure(8'd1, 4'd2, 16'd3);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    repeat (4) send_item(sfm_pkg::FN_TICK, 8'($urandom));
    send_item(sfm_pkg::FN_START, 8'($urandom));
    send_item(sfm_pkg::FN_RX, 8'h00);
    tick_until_done();
    configure(8'd1, 4'd2, 16'd0);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    tick_until_done();
  endtask

  task automatic test_live_registers();
    configure(8'd1, 4'd2, 16'd5);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    wait_idle();
    write_reg(sfm_pkg::CFG_COUNT, 16'h000C);
    make_frame(8'd1, 2, 8'h00, -1);
    send_frame(sfm_pkg::FN_RX, 1'b0, 0);
    tick_until_done();
    configure(8'd1, 4'd2, 16'd5);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    wait_idle();
    write_reg(sfm_pkg::CFG_ID, 16'h0009);
    make_frame(8'd9, 2, 8'h00, -1);
    send_frame(sfm_pkg::FN_RX, 1'b0, 0);
  endtask

  task automatic test_restart();
    configure(8'd3, 4'd1, 16'd10);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    make_frame(8'd3, 1, 8'h00, -1);
    for (int i = 0; i < 4; i++) send_item(sfm_pkg::FN_RX, frame_bytes[i]);
    send_item(sfm_pkg::FN_START, 8'($urandom));
    for (int i = 4; i < frame_bytes.size(); i++) send_item(sfm_pkg::FN_RX, frame_bytes[i]);
    send_frame(sfm_pkg::FN_RX, 1'b0, 0);
  endtask

  task automatic test_random_traffic();
    int first_item;
    int txn;
    int cnt;
    int k;
    first_item = live_items;
    txn = 0;
    while (live_items - first_item < RANDOM_ITEMS) begin
      if (txn % 4 == 0)
        configure(8'(($urandom_range(0, 9) == 0) ? $urandom_range(254, 255)
                                                 : $urandom_range(0, 253)),
                  4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                 : $urandom_range(0, 8)),
                  16'($urandom_range(0, 15)));
      txn++;
      gaps_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      send_item(sfm_pkg::FN_START, 8'($urandom));
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 4))
          send_item(sfm_pkg::func_t'($urandom_range(1, 3)), 8'($urandom));
      cnt = (reg_count > sfm_pkg::MAX_PARAMS) ? $urandom_range(0, sfm_pkg::MAX_PARAMS)
                                              : int'(reg_count);
      make_frame(8'($urandom), $urandom_range(0, 10), 8'($urandom), -1);
      req_frame = frame_bytes;
      make_frame(reg_id, cnt, $urandom_range(0, 1) ? 8'h00 : 8'($urandom), -1);
      if ($urandom_range(0, 3) == 0) begin
        req_frame = frame_bytes;
        make_frame(reg_id, cnt, $urandom_range(0, 1) ? 8'h00 : 8'($urandom), -1);
      end
      send_frame(sfm_pkg::FN_REQ, 1'b1, 5);
      if ($urandom_range(0, 1)) send_frame(sfm_pkg::FN_RX, 1'b1, 10);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) send_item(sfm_pkg::FN_RX, 8'($urandom));
      case ($urandom_range(0, 9))
        0: begin
          k = $urandom_range(0, frame_bytes.size() - 1);
          frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
          send_frame(sfm_pkg::FN_RX, 1'b0, 10);
        end
        1: begin
          repeat ($urandom_range(1, frame_bytes.size() - 1))
            frame_bytes.delete(frame_bytes.size() - 1);
          send_frame(sfm_pkg::FN_RX, 1'b0, 10);
        end
        2: ;
        default: send_frame(sfm_pkg::FN_RX, 1'b0, 10);
      endcase
      tick_until_done();
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < sfm_pkg::WIN; i++) begin
      win_bytes[i] = 8'h00;
      req_bytes[i] = 8'h00;
    end
    req_len     = 0;
    rx_seen     = 0;
    ticks_seen  = 0;
    txn_done    = 1'b1;
    reg_id      = 8'd1;
    reg_count   = 4'd2;
    reg_timeout = 16'd10;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_frame_matches();
    test_echo_rejection();
    test_bad_config();
    test_timer_expiry();
    test_live_registers();
    test_restart();
    test_random_traffic();
    wait_idle();
    $display("run covered %0d live bus items in %0d transactions, %0d status beats checked",
             live_items, txn_count, beats_seen);
    $display("%0d field mismatches found", mismatch_count);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
